[src/cmc_pkg.sv]
// Shared constants, coefficient tables and rounding helpers for the colour matrix composer.
package cmc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int WIDE_W        = 64;
    localparam int CORDIC_W      = 34;
    localparam int NUM_COEFS     = 20;
    localparam int ADJ_ENTRIES   = 9;

    // adjustment commands
    localparam logic [2:0] CMD_HUE      = 3'd0;
    localparam logic [2:0] CMD_SAT      = 3'd1;
    localparam logic [2:0] CMD_BRIGHT   = 3'd2;
    localparam logic [2:0] CMD_CONTRAST = 3'd3;
    localparam logic [2:0] CMD_INVERT   = 3'd4;

    // sequencer limits
    localparam logic [4:0] CORDIC_LAST = 5'd23;
    localparam logic [4:0] ATAN_ROWS   = 5'd10;
    localparam logic [3:0] ADJ_LAST    = 4'd8;
    localparam logic [1:0] LUMA_LAST   = 2'd2;
    localparam logic [1:0] LAST_ROW    = 2'd3;
    localparam logic [2:0] LAST_COL    = 3'd4;
    localparam logic [2:0] LAST_TERM   = 3'd4;
    localparam logic [4:0] LAST_IDX    = 5'd19;

    localparam logic signed [WIDE_W-1:0]   PI_Q30      = 64'sd3373259426;
    localparam logic signed [WIDE_W-1:0]   HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [COEF_W-1:0] BRIGHT_GAIN   = 32'sd255;
    localparam logic signed [COEF_W-1:0] CONTRAST_GAIN = -32'sd128;

    localparam logic signed [COEF_W-1:0] ATAN_Q30 [10] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159, 32'sd67021687,
        32'sd33543516, 32'sd16775851, 32'sd8388437, 32'sd4194283, 32'sd2097149
    };

    localparam logic signed [COEF_W-1:0] LUMA_Q30 [3] = '{
        32'sd321048805, 32'sd630286451, 32'sd122406568
    };
    localparam logic signed [COEF_W-1:0] NEG_LUMA_Q30 [3] = '{
        -32'sd321048805, -32'sd630286451, -32'sd122406568
    };

    // hue entry = luma[col] + cos * COS_K + sin * SIN_K, row-major 3x3
    localparam logic signed [COEF_W-1:0] COS_K [9] = '{
        32'sd752693019, -32'sd630286451, -32'sd122406568,
        -32'sd321048805, 32'sd443455373, -32'sd122406568,
        -32'sd321048805, -32'sd630286451, 32'sd951335256
    };
    localparam logic signed [COEF_W-1:0] SIN_K [9] = '{
        -32'sd321048805, -32'sd630286451, 32'sd951335256,
        32'sd153545081, 32'sd150323855, -32'sd303868936,
        -32'sd752693019, 32'sd630286451, 32'sd122406568
    };

    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[COEF_W-1:0];
    endfunction

    // round a Q30 x Q30 product back to Q30
    function automatic logic signed [CORDIC_W-1:0] mulq30(input logic signed [WIDE_W-1:0] p);
        logic signed [WIDE_W-1:0] t;
        t = p + 64'sd536870912;
        return t[WIDE_W-1:30];
    endfunction

    function automatic logic signed [CORDIC_W-1:0] cordic_step(input logic [4:0] i);
        if (i < ATAN_ROWS) begin
            return CORDIC_W'(ATAN_Q30[i[3:0]]);
        end
        return CORDIC_W'(64'sd1 <<< (5'd30 - i));
    endfunction

endpackage

[src/color_matrix_composer.sv]
// Colour matrix composer: premultiplies a stored 4x5 affine matrix by one adjustment per transaction.
// Hue uses a 24-step CORDIC; all terms are formed on the shared 32x32 multiplier.
// Throughput: one adjustment per run; no new command is accepted until the run's last coefficient is taken.
// Reset (aresetn low, synchronous): matrix goes to identity with zero offsets, sequencer to idle.
// Commands 5 to 7 are accepted and dropped: they leave the matrix alone and emit nothing.
module color_matrix_composer import cmc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] amount
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [4:0] coef_index, [36:5] coefficient, [39:37] zero
    output logic        m_axis_tlast
);

    localparam int Q_SH  = 30 - FRAC_BITS;
    localparam int ANG_W = COEF_W + Q_SH;
    localparam int HW    = 36;
    localparam int ACC_W = WIDE_W - FRAC_BITS + 3;

    localparam logic signed [COEF_W-1:0] ONE     = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [COEF_W-1:0] NEG_ONE = -ONE;
    localparam logic signed [COEF_W-1:0] INV_OFF = sat32(64'sd255 <<< FRAC_BITS);
    localparam logic signed [ANG_W-1:0]  PI_A    = ANG_W'(PI_Q30);
    localparam logic signed [ANG_W-1:0]  HALF_A  = ANG_W'(HALF_PI_Q30);
    localparam logic signed [HW-1:0]     HRND    = HW'(64'd1 << (Q_SH - 1));
    localparam logic signed [WIDE_W-1:0] MRND    = WIDE_W'(64'd1 << (FRAC_BITS - 1));

    typedef enum logic [3:0] {
        ST_IDLE, ST_H_INIT, ST_H_ROT, ST_H_FIN, ST_H_C, ST_H_S, ST_H_E,
        ST_S_M, ST_S_W, ST_B_M, ST_B_W, ST_M_RUN, ST_M_OUT
    } state_t;

    state_t state_reg;

    logic [2:0]                 cmd_reg;
    logic signed [COEF_W-1:0]   amt_reg;
    logic signed [COEF_W-1:0]   m_reg [NUM_COEFS];   // stored matrix
    logic signed [COEF_W-1:0]   n_reg [NUM_COEFS];   // matrix under construction
    logic signed [COEF_W-1:0]   adj_reg [ADJ_ENTRIES];
    logic signed [COEF_W-1:0]   off_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic                       neg_reg;
    logic [4:0]                 i_reg;
    logic [3:0]                 e_reg;
    logic [1:0]                 hk_reg, sk_reg, mr_reg;
    logic [2:0]                 mx_reg, mk_reg;
    logic [4:0]                 oidx_reg;
    logic signed [HW-1:0]       hacc_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [COEF_W-1:0]   coef_reg;
    logic                       m_valid_reg;
    logic signed [WIDE_W-1:0]   prod_reg;

    logic signed [COEF_W-1:0]   mul_a, mul_b, a_sel, m_rd;
    logic signed [CORDIC_W-1:0] x_next, y_next, z_next, step, z0;
    logic                       neg0;
    logic signed [ANG_W-1:0]    ang, zc;
    logic signed [HW-1:0]       hacc_next, hv, hr;
    logic signed [COEF_W-1:0]   hue_entry;
    logic signed [CORDIC_W-1:0] sat_w;
    logic signed [WIDE_W-1:0]   sat_d, mrnd;
    logic signed [ACC_W-1:0]    acc_init, acc_next;
    logic signed [COEF_W-1:0]   coef_res, bc_dia;

    // ---- angle clamp to +-pi and fold into +-pi/2 ----
    always_comb begin
        ang = {amt_reg, {Q_SH{1'b0}}};
        if (ang > PI_A) begin
            zc = PI_A;
        end else if (ang < -PI_A) begin
            zc = -PI_A;
        end else begin
            zc = ang;
        end
        if (zc > HALF_A) begin
            z0   = CORDIC_W'(zc - PI_A);
            neg0 = 1'b1;
        end else if (zc < -HALF_A) begin
            z0   = CORDIC_W'(zc + PI_A);
            neg0 = 1'b1;
        end else begin
            z0   = CORDIC_W'(zc);
            neg0 = 1'b0;
        end
    end

    // ---- one CORDIC micro-rotation per cycle ----
    always_comb begin
        step = cordic_step(i_reg);
        if (z_reg >= 0) begin
            x_next = x_reg - (y_reg >>> i_reg);
            y_next = y_reg + (x_reg >>> i_reg);
            z_next = z_reg - step;
        end else begin
            x_next = x_reg + (y_reg >>> i_reg);
            y_next = y_reg - (x_reg >>> i_reg);
            z_next = z_reg + step;
        end
    end

    // ---- hue entry: luma + round(c*k1) + round(s*k2), then back to the output format ----
    assign hacc_next = HW'(LUMA_Q30[hk_reg]) + HW'(mulq30(prod_reg));
    assign hv        = hacc_reg + HW'(mulq30(prod_reg));
    assign hr        = hv + HRND;
    assign hue_entry = sat32(WIDE_W'($signed(hr[HW-1:Q_SH])));

    // ---- saturation, brightness and contrast terms ----
    assign sat_w  = mulq30(prod_reg);
    assign sat_d  = WIDE_W'(amt_reg) + WIDE_W'(ONE);
    assign bc_dia = (cmd_reg == CMD_BRIGHT) ? ONE : sat32(sat_d);

    // ---- matrix product operand selection ----
    always_comb begin
        if (mr_reg == LAST_ROW) begin
            a_sel = (mk_reg == 3'd3) ? ONE : '0;
        end else if (mk_reg == 3'd3) begin
            a_sel = '0;
        end else begin
            a_sel = adj_reg[4'(mr_reg) * 4'd3 + 4'(mk_reg[1:0])];
        end
    end

    assign m_rd     = m_reg[5'(mk_reg[1:0]) * 5'd5 + 5'(mx_reg)];
    assign acc_init = (mx_reg == LAST_COL && mr_reg != LAST_ROW) ? ACC_W'(off_reg) : '0;
    assign mrnd     = prod_reg + MRND;
    assign acc_next = acc_reg + ACC_W'($signed(mrnd[WIDE_W-1:FRAC_BITS]));
    assign coef_res = sat32(WIDE_W'(acc_next));

    // ---- shared multiplier: operands by sequencer state ----
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_H_C: begin
                mul_a = x_reg[COEF_W-1:0];
                mul_b = COS_K[e_reg];
            end
            ST_H_S: begin
                mul_a = y_reg[COEF_W-1:0];
                mul_b = SIN_K[e_reg];
            end
            ST_S_M: begin
                mul_a = amt_reg;
                mul_b = NEG_LUMA_Q30[sk_reg];
            end
            ST_B_M: begin
                mul_a = amt_reg;
                mul_b = (cmd_reg == CMD_BRIGHT) ? BRIGHT_GAIN : CONTRAST_GAIN;
            end
            ST_M_RUN: begin
                mul_a = a_sel;
                mul_b = m_rd;
            end
            default: ;
        endcase
    end

    // register every product before it is used
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // ---- sequencer ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_COEFS; i++) begin
                m_reg[i] <= (i % 6 == 0) ? ONE : '0;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        cmd_reg  <= s_axis_tuser;
                        amt_reg  <= s_axis_tdata;
                        for (int i = 0; i < ADJ_ENTRIES; i++) begin
                            adj_reg[i] <= '0;
                        end
                        off_reg  <= '0;
                        hacc_reg <= '0;
                        e_reg    <= '0;
                        hk_reg   <= '0;
                        sk_reg   <= '0;
                        mr_reg   <= '0;
                        mx_reg   <= '0;
                        mk_reg   <= '0;
                        oidx_reg <= '0;
                        unique case (s_axis_tuser) inside
                            CMD_HUE:                state_reg <= ST_H_INIT;
                            CMD_SAT:                state_reg <= ST_S_M;
                            CMD_BRIGHT, CMD_CONTRAST: state_reg <= ST_B_M;
                            CMD_INVERT: begin
                                adj_reg[0] <= NEG_ONE;
                                adj_reg[4] <= NEG_ONE;
                                adj_reg[8] <= NEG_ONE;
                                off_reg    <= INV_OFF;
                                state_reg  <= ST_M_RUN;
                            end
                            default:                state_reg <= ST_IDLE; // drop unknown
                        endcase
                    end
                end
                ST_H_INIT: begin
                    x_reg     <= CORDIC_GAIN;
                    y_reg     <= '0;
                    z_reg     <= z0;
                    neg_reg   <= neg0;
                    i_reg     <= '0;
                    state_reg <= ST_H_ROT;
                end
                ST_H_ROT: begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                    z_reg <= z_next;
                    if (i_reg == CORDIC_LAST) begin
                        state_reg <= ST_H_FIN;
                    end else begin
                        i_reg <= i_reg + 5'd1;
                    end
                end
                ST_H_FIN: begin
                    if (neg_reg) begin
                        x_reg <= -x_reg;
                        y_reg <= -y_reg;
                    end
                    state_reg <= ST_H_C;
                end
                ST_H_C: state_reg <= ST_H_S;
                ST_H_S: begin
                    hacc_reg  <= hacc_next;
                    state_reg <= ST_H_E;
                end
                ST_H_E: begin
                    adj_reg[e_reg] <= hue_entry;
                    e_reg  <= e_reg + 4'd1;
                    hk_reg <= (hk_reg == LUMA_LAST) ? 2'd0 : hk_reg + 2'd1;
                    state_reg <= (e_reg == ADJ_LAST) ? ST_M_RUN : ST_H_C;
                end
                ST_S_M: state_reg <= ST_S_W;
                ST_S_W: begin
                    // one luma column: weight everywhere, plus the gain on the diagonal
                    for (int r = 0; r < 3; r++) begin
                        adj_reg[4'(r * 3) + 4'(sk_reg)] <=
                            sat32(WIDE_W'(sat_w) + ((2'(r) == sk_reg) ? sat_d : '0));
                    end
                    sk_reg    <= sk_reg + 2'd1;
                    state_reg <= (sk_reg == LUMA_LAST) ? ST_M_RUN : ST_S_M;
                end
                ST_B_M: state_reg <= ST_B_W;
                ST_B_W: begin
                    off_reg    <= sat32(prod_reg);
                    adj_reg[0] <= bc_dia;
                    adj_reg[4] <= bc_dia;
                    adj_reg[8] <= bc_dia;
                    state_reg  <= ST_M_RUN;
                end
                ST_M_RUN: begin
                    // issue term mk, accumulate term mk-1
                    if (mk_reg == 3'd0) begin
                        acc_reg <= acc_init;
                    end else begin
                        acc_reg <= acc_next;
                    end
                    if (mk_reg == LAST_TERM) begin
                        n_reg[oidx_reg] <= coef_res;
                        coef_reg        <= coef_res;
                        m_valid_reg     <= 1'b1;
                        state_reg       <= ST_M_OUT;
                    end else begin
                        mk_reg <= mk_reg + 3'd1;
                    end
                end
                ST_M_OUT: begin
                    if (m_axis_tready) begin
                        m_valid_reg <= 1'b0;
                        mk_reg      <= '0;
                        if (oidx_reg == LAST_IDX) begin
                            for (int i = 0; i < NUM_COEFS; i++) begin
                                m_reg[i] <= n_reg[i];
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            oidx_reg <= oidx_reg + 5'd1;
                            if (mx_reg == LAST_COL) begin
                                mx_reg <= '0;
                                mr_reg <= mr_reg + 2'd1;
                            end else begin
                                mx_reg <= mx_reg + 3'd1;
                            end
                            state_reg <= ST_M_RUN;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---- ports ----
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, coef_reg, oidx_reg};
    assign m_axis_tlast  = (oidx_reg == LAST_IDX);

    // ---- assertions ----
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a coefficient is pending");

    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser <= CMD_INVERT) |=> !s_axis_tready)
        else $error("ready again straight after a valid command");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid))
        else $error("not idle after the final coefficient");

    a_gap_between: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("run ended or repeated a coefficient early");

endmodule

[bench/tb_color_matrix_composer.sv]
// Self-checking testbench for the colour matrix composer: predicts each composed matrix.
`timescale 1ns / 1ps

module tb_color_matrix_composer;
    import cmc_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] amount;
    } adjust_t;

    typedef struct packed {
        logic [4:0]  coef_index;
        logic [31:0] coefficient;
        logic        last;
    } coef_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    color_matrix_composer dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    adjust_t pending_adjusts[$];
    coef_t   expected_coefs[$];
    longint  model_matrix[20];
    int      fail_count = 0;
    bit      quiet_phase = 1'b0;
    bit      hold_sender = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;
    logic    s_axis_tready_q = 1'b0;

    // Luma weights and hue tables in Q30, rebuilt here independently
    localparam longint LR = 321048805, LG = 630286451, LB = 122406568;
    localparam longint ONE30 = longint'(1) << 30;
    longint luma_w[3] = '{LR, LG, LB};
    longint cos_tab[3][3] = '{'{ONE30 - LR, -LG, -LB}, '{-LR, ONE30 - LG, -LB},
                              '{-LR, -LG, ONE30 - LB}};
    longint sin_tab[3][3] = '{'{-LR, -LG, ONE30 - LB}, '{153545081, 150323855, -303868936},
                              '{-(ONE30 - LR), LG, LB}};
    longint atan_tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rotate the gain-compensated unit vector by the clamped angle (Q30)
    function automatic void rotate_angle(longint ang, output longint c, output longint s);
        longint x, y, z, nx, stp;
        bit flip;
        x = 652032874; y = 0; z = ang; flip = 1'b0;
        if (z > PI_Q30) z = PI_Q30;
        if (z < -PI_Q30) z = -PI_Q30;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30; flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30; flip = 1'b1;
        end
        for (int i = 0; i < 24; i++) begin
            stp = (i < 10) ? atan_tab[i] : (longint'(1) << (30 - i));
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= stp;
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += stp;
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Compose one adjustment onto the model matrix and queue the 20 new coefficients
    task automatic compose_adjustment(adjust_t a);
        longint adj[4][5];
        longint one, amt, c, s, dia, off, acc, w;
        longint nxt[20];
        coef_t  cf;
        one = longint'(1) << FB;
        amt = longint'($signed(a.amount));
        if (a.command > CMD_INVERT) return;
        foreach (adj[r, k]) adj[r][k] = 0;
        adj[3][3] = one;
        case (a.command)
            CMD_HUE: begin
                rotate_angle(amt * (longint'(1) << (30 - FB)), c, s);
                for (int r = 0; r < 3; r++)
                    for (int k = 0; k < 3; k++)
                        adj[r][k] = (luma_w[k] + ((c * cos_tab[r][k] + (1 << 29)) >>> 30)
                                    + ((s * sin_tab[r][k] + (1 << 29)) >>> 30)
                                    + (longint'(1) << (29 - FB))) >>> (30 - FB);
            end
            CMD_SAT: begin
                for (int r = 0; r < 3; r++)
                    for (int k = 0; k < 3; k++) begin
                        w = (-amt * luma_w[k] + (longint'(1) << 29)) >>> 30;
                        adj[r][k] = (r == k) ? w + amt + one : w;
                    end
            end
            default: begin
                if (a.command == CMD_BRIGHT) begin
                    dia = one; off = amt * 255;
                end else if (a.command == CMD_CONTRAST) begin
                    dia = amt + one; off = -128 * amt;
                end else begin
                    dia = -one; off = 255 * one;
                end
                for (int r = 0; r < 3; r++) begin
                    adj[r][r] = dia; adj[r][4] = off;
                end
            end
        endcase
        foreach (adj[r, k]) adj[r][k] = clip32(adj[r][k]);
        for (int r = 0; r < 4; r++)
            for (int x = 0; x < 5; x++) begin
                acc = (x == 4) ? adj[r][4] : 0;
                for (int k = 0; k < 4; k++)
                    acc += (adj[r][k] * model_matrix[k * 5 + x]
                            + (longint'(1) << (FB - 1))) >>> FB;
                nxt[r * 5 + x] = clip32(acc);
            end
        for (int k = 0; k < 20; k++) begin
            model_matrix[k] = nxt[k];
            cf.coef_index = 5'(k);
            cf.coefficient = nxt[k][31:0];
            cf.last = (k == 19);
            expected_coefs.push_back(cf);
        end
    endtask

    // Driver: present queued adjustments at the falling edge, with random gaps, and stall tready at random
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready_q) begin
                void'(pending_adjusts.pop_front());
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!quiet_phase && !(s_axis_tvalid && !s_axis_tready_q)
                         && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 13);
                s_axis_tvalid <= 1'b0;
            end else if (pending_adjusts.size() > 0 && !hold_sender) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_adjusts[0].command;
                s_axis_tdata  <= pending_adjusts[0].amount;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
                recv_gap <= $urandom_range(1, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Record the input handshake seen at the rising edge; predict from it
    always @(posedge aclk) begin
        s_axis_tready_q <= s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready)
            compose_adjustment(adjust_t'{s_axis_tuser, s_axis_tdata});
    end

    // Monitor: compare each output transaction with the oldest expectation
    always @(posedge aclk) begin
        coef_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_coefs.size() == 0) begin
                $error("unexpected coefficient transaction, index %0d", m_axis_tdata[4:0]);
                fail_count++;
            end else begin
                want = expected_coefs.pop_front();
                if (m_axis_tdata[4:0] !== want.coef_index) begin
                    $error("coef_index: expected %0d, got %0d", want.coef_index,
                           m_axis_tdata[4:0]);
                    fail_count++;
                end
                if (m_axis_tdata[36:5] !== want.coefficient) begin
                    $error("coefficient: expected %0d, got %0d", $signed(want.coefficient),
                           $signed(m_axis_tdata[36:5]));
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] random_amount();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
            2: return 32'($signed($urandom_range(0, 8192)) - 4096);
            3: return 32'($signed($urandom_range(0, 6 * 205887)) - 3 * 205887);
            default: return 32'($signed($urandom_range(0, 131072)) - 65536) & 32'hffff_fff0;
        endcase
    endfunction

    task automatic queue_adjust(logic [2:0] cmd, logic [31:0] amt);
        pending_adjusts.push_back(adjust_t'{cmd, amt});
    endtask

    initial begin
        adjust_t item;
        model_matrix = '{default: 0};
        for (int i = 0; i < 4; i++) model_matrix[i * 6] = longint'(1) << FB;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: each adjustment, field extremes, clamped hue, unknown commands
        queue_adjust(CMD_INVERT, 32'h0);
        queue_adjust(CMD_HUE, 32'h0);
        queue_adjust(CMD_HUE, 32'h0001_9220);        // just over pi/2
        queue_adjust(CMD_HUE, 32'hfffe_6de0);        // just under -pi/2
        queue_adjust(CMD_HUE, 32'h7fff_ffff);        // clamped to +pi
        queue_adjust(CMD_HUE, 32'h8000_0000);        // clamped to -pi
        queue_adjust(CMD_SAT, 32'hffff_0000);
        queue_adjust(CMD_SAT, 32'h0000_8000);
        queue_adjust(CMD_BRIGHT, 32'h0000_2000);
        queue_adjust(CMD_CONTRAST, 32'h0000_4000);
        queue_adjust(3'd5, 32'h1234_5678);
        queue_adjust(3'd6, 32'hffff_ffff);
        queue_adjust(3'd7, 32'h0);
        queue_adjust(CMD_BRIGHT, 32'h7fff_ffff);     // offsets saturate
        queue_adjust(CMD_CONTRAST, 32'h7fff_ffff);
        queue_adjust(CMD_SAT, 32'h8000_0000);
        queue_adjust(CMD_INVERT, 32'hffff_ffff);
        queue_adjust(CMD_CONTRAST, 32'h8000_0000);

        // Hold off the sender until all results of the directed part are back
        wait (pending_adjusts.size() == 0);
        hold_sender = 1'b1;
        wait (expected_coefs.size() == 0);
        repeat (200) @(posedge aclk);
        hold_sender = 1'b0;

        // Random: mostly small adjustments so the matrix stays interesting
        for (int n = 0; n < 350; n++) begin
            item.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                        : 3'($urandom_range(0, 4));
            item.amount = random_amount();
            pending_adjusts.push_back(item);
            if (n == 300) begin
                wait (pending_adjusts.size() == 0);
                quiet_phase = 1'b1;
            end
        end

        wait (pending_adjusts.size() == 0);
        wait (expected_coefs.size() == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** color_matrix_composer: PASSED **");
        end else begin
            $display("** color_matrix_composer: FAILED **");
        end
        $finish;
    end

    // Watchdog: fails the test if it has not finished in time
    initial begin
        #(4 * 1500000);
        $display("** color_matrix_composer: FAILED **");
        $finish;
    end

endmodule
